FILE: rtl/core/metp_pkg.sv
// Shared types, constants and helpers of the Mandelbrot escape-time pixel unit.
package metp_pkg;

    localparam int IMAGE_SIZE_DEFAULT = 4096;
    localparam int FRAC_BITS_DEFAULT  = 26;

    localparam int IDX_W     = 12;
    localparam int WORD_W    = 32;
    localparam int ITER_W    = 16;
    localparam int LEVEL_W   = 17;
    localparam int COUNT_W   = 25;
    localparam int PRODUCT_W = 64;

    localparam logic [COUNT_W-1:0] COUNT_CAP = 25'd16777216;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RE_ORIGIN = 3'd0,
        REG_RE_STEP   = 3'd1,
        REG_IM_ORIGIN = 3'd2,
        REG_IM_STEP   = 3'd3,
        REG_MAX_ITER  = 3'd4
    } reg_index_t;

    localparam logic signed [WORD_W-1:0] RE_ORIGIN_RESET = -32'sd134217728;
    localparam logic signed [WORD_W-1:0] RE_STEP_RESET   = 32'sd65536;
    localparam logic signed [WORD_W-1:0] IM_ORIGIN_RESET = -32'sd67108864;
    localparam logic signed [WORD_W-1:0] IM_STEP_RESET   = 32'sd65536;
    localparam logic [ITER_W-1:0]        MAX_ITER_RESET  = 16'd256;

    localparam logic signed [PRODUCT_W-1:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [PRODUCT_W-1:0] SAT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [WORD_W-1:0] re_origin;
        logic signed [WORD_W-1:0] re_step;
        logic signed [WORD_W-1:0] im_origin;
        logic signed [WORD_W-1:0] im_step;
    } map_cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] c_re;
        logic signed [WORD_W-1:0] c_im;
        logic                     frame_start;
    } pixel_job_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [PRODUCT_W-1:0] v
    );
        logic signed [WORD_W-1:0] r;
        priority if (v > SAT_MAX)
        begin
            r = SAT_MAX[WORD_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[WORD_W-1:0];
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/metp_front.sv
// Front part: accepts a pixel, reduces its indices and maps them to the point c.
module metp_front #(
    parameter int IMAGE_SIZE = metp_pkg::IMAGE_SIZE_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [metp_pkg::IDX_W-1:0]       pixel_col,
    input  logic [metp_pkg::IDX_W-1:0]       pixel_row,
    input  logic                             frame_start,
    input  metp_pkg::map_cfg_t               cfg,
    output logic                             job_wr,
    output metp_pkg::pixel_job_t             job_data,
    input  logic                             job_full
);

    localparam int IDX_W  = metp_pkg::IDX_W;
    localparam int MOD_W  = 32;
    localparam int PROD_W = IDX_W + 1 + metp_pkg::WORD_W;
    localparam int WIDE_W = metp_pkg::PRODUCT_W;

    // reciprocal of the image size, exact for every index that fits in IDX_W bits
    localparam int     SIZE_LOG    = $clog2(IMAGE_SIZE);
    localparam int     RECIP_SHIFT = IDX_W + SIZE_LOG;
    localparam int     RECIP_W     = IDX_W + 2;
    localparam int     QPROD_W     = IDX_W + RECIP_W;
    localparam longint RECIP_VAL   =
        ((longint'(1) << RECIP_SHIFT) + longint'(IMAGE_SIZE) - 1) / longint'(IMAGE_SIZE);

    localparam logic [QPROD_W-1:0] RECIP  = QPROD_W'(RECIP_VAL);
    localparam logic [MOD_W-1:0]   SIZE_C = MOD_W'(IMAGE_SIZE);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_QUOT = 5'b00010,
        F_REM  = 5'b00100,
        F_MAP  = 5'b01000,
        F_SAT  = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [IDX_W-1:0]         col_reg, col_next;
    logic [IDX_W-1:0]         row_reg, row_next;
    logic                     frame_reg, frame_next;
    logic [IDX_W-1:0]         col_q_reg, col_q_next;
    logic [IDX_W-1:0]         row_q_reg, row_q_next;
    logic signed [PROD_W-1:0] prod_re_reg, prod_re_next;
    logic signed [PROD_W-1:0] prod_im_reg, prod_im_next;

    logic signed [WIDE_W-1:0] sum_re;
    logic signed [WIDE_W-1:0] sum_im;
    logic [QPROD_W-1:0]       col_qprod;
    logic [QPROD_W-1:0]       row_qprod;
    logic [MOD_W-1:0]         col_back;
    logic [MOD_W-1:0]         row_back;

    assign full = (state_reg != F_IDLE);

    assign col_qprod = QPROD_W'(col_reg) * RECIP;
    assign row_qprod = QPROD_W'(row_reg) * RECIP;
    assign col_back  = MOD_W'(col_q_reg) * SIZE_C;
    assign row_back  = MOD_W'(row_q_reg) * SIZE_C;

    assign sum_re = WIDE_W'(cfg.re_origin) + WIDE_W'(prod_re_reg);
    assign sum_im = WIDE_W'(cfg.im_origin) + WIDE_W'(prod_im_reg);

    assign job_data.c_re        = metp_pkg::sat_word(sum_re);
    assign job_data.c_im        = metp_pkg::sat_word(sum_im);
    assign job_data.frame_start = frame_reg;

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        frame_next   = frame_reg;
        col_q_next   = col_q_reg;
        row_q_next   = row_q_reg;
        prod_re_next = prod_re_reg;
        prod_im_next = prod_im_reg;
        job_wr       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    col_next   = pixel_col;
                    row_next   = pixel_row;
                    frame_next = frame_start;
                    state_next = F_QUOT;
                end
            end
            F_QUOT:
            begin
                // quotient by the image size through its reciprocal
                col_q_next = IDX_W'(col_qprod >> RECIP_SHIFT);
                row_q_next = IDX_W'(row_qprod >> RECIP_SHIFT);
                state_next = F_REM;
            end
            F_REM:
            begin
                col_next   = col_reg - col_back[IDX_W-1:0];
                row_next   = row_reg - row_back[IDX_W-1:0];
                state_next = F_MAP;
            end
            F_MAP:
            begin
                prod_re_next = PROD_W'($signed({1'b0, col_reg})) * PROD_W'(cfg.re_step);
                prod_im_next = PROD_W'($signed({1'b0, row_reg})) * PROD_W'(cfg.im_step);
                state_next   = F_SAT;
            end
            F_SAT:
            begin
                // hold the job until the queue has room
                if (!job_full)
                begin
                    job_wr     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        frame_reg   <= frame_next;
        col_q_reg   <= col_q_next;
        row_q_reg   <= row_q_next;
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
    end

endmodule

FILE: rtl/core/metp_queue.sv
// Short job queue between the front and the back part.
module metp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  metp_pkg::pixel_job_t wr_data,
    output logic                 full,
    input  logic                 rd_en,
    output metp_pkg::pixel_job_t rd_data,
    output logic                 empty
);

    localparam int DEPTH = metp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    metp_pkg::pixel_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        priority if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("job queue written while full");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("job queue read while empty");
`endif

endmodule

FILE: rtl/core/metp_iter.sv
// Back part: iterates z = z*z + c, divides the count into a level and holds the result.
module metp_iter #(
    parameter int FRAC_BITS = metp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_empty,
    output logic                              job_rd,
    input  metp_pkg::pixel_job_t              job_data,
    input  logic [metp_pkg::ITER_W-1:0]       max_iterations,
    input  logic                              pop,
    output logic                              empty,
    output logic [metp_pkg::ITER_W-1:0]       iteration_count,
    output logic                              inside_res,
    output logic [metp_pkg::LEVEL_W-1:0]      level,
    output logic [metp_pkg::COUNT_W-1:0]      inside_count
);

    localparam int WORD_W  = metp_pkg::WORD_W;
    localparam int ITER_W  = metp_pkg::ITER_W;
    localparam int LEVEL_W = metp_pkg::LEVEL_W;
    localparam int COUNT_W = metp_pkg::COUNT_W;
    localparam int WIDE_W  = metp_pkg::PRODUCT_W;
    localparam int DIV_W   = $clog2(ITER_W);

    localparam int               THR_SHIFT = 2 * FRAC_BITS + 4;
    localparam logic             REACHABLE = (THR_SHIFT < WIDE_W);
    localparam logic [WIDE_W-1:0] THR      = REACHABLE ? (WIDE_W'(1) << THR_SHIFT) : '0;
    localparam logic [DIV_W-1:0] DIV_LAST  = DIV_W'(ITER_W - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << ITER_W;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_STEP = 5'b00100,
        B_DIV  = 5'b01000,
        B_OUT  = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [WORD_W-1:0] zre_reg, zre_next;
    logic signed [WORD_W-1:0] zim_reg, zim_next;
    logic signed [WORD_W-1:0] cre_reg, cre_next;
    logic signed [WORD_W-1:0] cim_reg, cim_next;
    logic                     frame_reg, frame_next;
    logic [ITER_W-1:0]        k_reg, k_next;
    logic signed [WIDE_W-1:0] rr_reg, rr_next;
    logic signed [WIDE_W-1:0] ii_reg, ii_next;
    logic signed [WIDE_W-1:0] ri_reg, ri_next;
    logic [ITER_W-1:0]        cnt_reg, cnt_next;
    logic                     inside_reg, inside_next;
    logic [ITER_W-1:0]        rem_reg, rem_next;
    logic [LEVEL_W-1:0]       quo_reg, quo_next;
    logic [DIV_W-1:0]         div_cnt_reg, div_cnt_next;

    logic                     out_valid_reg, out_valid_next;
    logic [ITER_W-1:0]        out_count_reg, out_count_next;
    logic                     out_inside_reg, out_inside_next;
    logic [LEVEL_W-1:0]       out_level_reg, out_level_next;
    logic [COUNT_W-1:0]       total_reg, total_next;

    logic [WIDE_W-1:0]        mag;
    logic                     escape;
    logic signed [WIDE_W-1:0] re_diff;
    logic signed [WORD_W-1:0] nre;
    logic signed [WORD_W-1:0] nim;
    logic [ITER_W:0]          rem_shift;
    logic [ITER_W:0]          rem_diff;
    logic                     take;
    logic                     out_load;
    logic [COUNT_W-1:0]       total_base;

    // products of the current z give both its modulus and the next z
    assign mag     = rr_reg + ii_reg;
    assign escape  = REACHABLE && (mag > THR);
    assign re_diff = rr_reg - ii_reg;
    assign nre     = metp_pkg::sat_word((re_diff >>> FRAC_BITS) + WIDE_W'(cre_reg));
    assign nim     = metp_pkg::sat_word((ri_reg >>> (FRAC_BITS - 1)) + WIDE_W'(cim_reg));

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, max_iterations};
    assign take      = (max_iterations != '0) && (rem_shift >= {1'b0, max_iterations});

    assign total_base = frame_reg ? '0 : total_reg;

    assign empty           = !out_valid_reg;
    assign iteration_count = out_count_reg;
    assign inside_res      = out_inside_reg;
    assign level           = out_level_reg;
    assign inside_count    = total_reg;

    always_comb
    begin
        state_next      = state_reg;
        zre_next        = zre_reg;
        zim_next        = zim_reg;
        cre_next        = cre_reg;
        cim_next        = cim_reg;
        frame_next      = frame_reg;
        k_next          = k_reg;
        rr_next         = rr_reg;
        ii_next         = ii_reg;
        ri_next         = ri_reg;
        cnt_next        = cnt_reg;
        inside_next     = inside_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        job_rd          = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_rd     = 1'b1;
                    cre_next   = job_data.c_re;
                    cim_next   = job_data.c_im;
                    frame_next = job_data.frame_start;
                    zre_next   = '0;
                    zim_next   = '0;
                    k_next     = '0;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                rr_next    = zre_reg * zre_reg;
                ii_next    = zim_reg * zim_reg;
                ri_next    = zre_reg * zim_reg;
                state_next = B_MUL == state_reg ? B_STEP : B_IDLE;
            end
            B_STEP:
            begin
                priority if (escape)
                begin
                    // the step that produced this z is the escaping one
                    cnt_next     = k_reg - ITER_W'(1);
                    inside_next  = 1'b0;
                    rem_next     = k_reg - ITER_W'(1);
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = B_DIV;
                end
                else if (k_reg == max_iterations)
                begin
                    cnt_next     = k_reg;
                    inside_next  = 1'b1;
                    rem_next     = '0;
                    quo_next     = LEVEL_W'(1);
                    div_cnt_next = '0;
                    state_next   = B_DIV;
                end
                else
                begin
                    zre_next   = nre;
                    zim_next   = nim;
                    k_next     = k_reg + ITER_W'(1);
                    state_next = B_MUL;
                end
            end
            B_DIV:
            begin
                rem_next     = take ? rem_diff[ITER_W-1:0] : rem_shift[ITER_W-1:0];
                quo_next     = {quo_reg[LEVEL_W-2:0], take};
                div_cnt_next = div_cnt_reg + DIV_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                // drop into the output slot once it is free or being taken
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_inside_next = out_inside_reg;
        out_level_next  = out_level_reg;
        total_next      = total_reg;
        priority if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_count_next  = cnt_reg;
            out_inside_next = inside_reg;
            out_level_next  = quo_reg;
            if (inside_reg && (total_base < metp_pkg::COUNT_CAP))
            begin
                total_next = total_base + COUNT_W'(1);
            end
            else
            begin
                total_next = total_base;
            end
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zre_reg        <= zre_next;
        zim_reg        <= zim_next;
        cre_reg        <= cre_next;
        cim_reg        <= cim_next;
        frame_reg      <= frame_next;
        k_reg          <= k_next;
        rr_reg         <= rr_next;
        ii_reg         <= ii_next;
        ri_reg         <= ri_next;
        cnt_reg        <= cnt_next;
        inside_reg     <= inside_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_cnt_reg    <= div_cnt_next;
        out_count_reg  <= out_count_next;
        out_inside_reg <= out_inside_next;
        out_level_reg  <= out_level_next;
    end

`ifndef SYNTHESIS
    a_inside_level_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_inside_reg) |-> (out_level_reg == LEVEL_ONE))
        else $error("inside pixel without a full level");

    a_escaped_level_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_inside_reg) |-> !out_level_reg[LEVEL_W-1])
        else $error("escaped pixel with a level of one");

    a_no_escape_from_origin: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_STEP) && (k_reg == '0)) |-> !escape)
        else $error("escape reported before the first step");
`endif

endmodule

FILE: rtl/core/mandelbrot_escape_time_pixel_unit.sv
// Top level of the Mandelbrot escape-time pixel unit: configuration registers and part wiring.
//
// Each pushed pixel (column, row, frame start) yields one result in push order: the escape
// step count, an inside flag, the count over max_iterations as a Q1.16 level and the running
// inside-pixel count of the frame. The front part reduces the indices and maps them to c,
// overlapped with the back part's work on earlier pixels through a two-entry job queue.
// The back part sets the rate: each iterate step runs through its three 32x32 multipliers,
// then a bit-serial division forms the level and the result is loaded into the output
// register. A finished result waits in that register while the next pixel is already
// being iterated. Registers sit at byte addresses 0, 4, 8, 12 and 16 (re_origin, re_step,
// im_origin, im_step, max_iterations); the user must see that they are written only while
// the unit is idle, as the unit itself does not enforce it.
module mandelbrot_escape_time_pixel_unit #(
    parameter int IMAGE_SIZE = metp_pkg::IMAGE_SIZE_DEFAULT,
    parameter int FRAC_BITS  = metp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [metp_pkg::ADDR_W-1:0]       paddr,
    input  logic [metp_pkg::DATA_W-1:0]       pwdata,
    output logic [metp_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic [metp_pkg::IDX_W-1:0]        pixel_col,
    input  logic [metp_pkg::IDX_W-1:0]        pixel_row,
    input  logic                              frame_start,
    input  logic                              push,
    output logic                              full,
    output logic [metp_pkg::ITER_W-1:0]       iteration_count,
    output logic                              inside_res,
    output logic [metp_pkg::LEVEL_W-1:0]      level,
    output logic [metp_pkg::COUNT_W-1:0]      inside_count,
    output logic                              empty,
    input  logic                              pop
);

    localparam int WORD_W = metp_pkg::WORD_W;
    localparam int ITER_W = metp_pkg::ITER_W;
    localparam int DATA_W = metp_pkg::DATA_W;
    localparam int ADDR_W = metp_pkg::ADDR_W;

    logic signed [WORD_W-1:0] re_origin_reg, re_origin_next;
    logic signed [WORD_W-1:0] re_step_reg, re_step_next;
    logic signed [WORD_W-1:0] im_origin_reg, im_origin_next;
    logic signed [WORD_W-1:0] im_step_reg, im_step_next;
    logic [ITER_W-1:0]        max_iter_reg, max_iter_next;

    logic                     cfg_wr;
    metp_pkg::reg_index_t     reg_idx;
    metp_pkg::map_cfg_t       map_cfg;

    logic                     job_wr;
    logic                     job_full;
    logic                     job_rd;
    logic                     job_empty;
    metp_pkg::pixel_job_t     job_in;
    metp_pkg::pixel_job_t     job_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = metp_pkg::reg_index_t'(paddr[ADDR_W-1:2]);

    assign map_cfg.re_origin = re_origin_reg;
    assign map_cfg.re_step   = re_step_reg;
    assign map_cfg.im_origin = im_origin_reg;
    assign map_cfg.im_step   = im_step_reg;

    always_comb
    begin
        re_origin_next = re_origin_reg;
        re_step_next   = re_step_reg;
        im_origin_next = im_origin_reg;
        im_step_next   = im_step_reg;
        max_iter_next  = max_iter_reg;
        if (cfg_wr)
        begin
            // ignore writes beyond the register list
            unique case (reg_idx)
                metp_pkg::REG_RE_ORIGIN: re_origin_next = pwdata;
                metp_pkg::REG_RE_STEP:   re_step_next   = pwdata;
                metp_pkg::REG_IM_ORIGIN: im_origin_next = pwdata;
                metp_pkg::REG_IM_STEP:   im_step_next   = pwdata;
                metp_pkg::REG_MAX_ITER:  max_iter_next  = pwdata[ITER_W-1:0];
                default:
                begin
                    max_iter_next = max_iter_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            metp_pkg::REG_RE_ORIGIN: prdata = re_origin_reg;
            metp_pkg::REG_RE_STEP:   prdata = re_step_reg;
            metp_pkg::REG_IM_ORIGIN: prdata = im_origin_reg;
            metp_pkg::REG_IM_STEP:   prdata = im_step_reg;
            metp_pkg::REG_MAX_ITER:  prdata = DATA_W'(max_iter_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_origin_reg <= metp_pkg::RE_ORIGIN_RESET;
            re_step_reg   <= metp_pkg::RE_STEP_RESET;
            im_origin_reg <= metp_pkg::IM_ORIGIN_RESET;
            im_step_reg   <= metp_pkg::IM_STEP_RESET;
            max_iter_reg  <= metp_pkg::MAX_ITER_RESET;
        end
        else
        begin
            re_origin_reg <= re_origin_next;
            re_step_reg   <= re_step_next;
            im_origin_reg <= im_origin_next;
            im_step_reg   <= im_step_next;
            max_iter_reg  <= max_iter_next;
        end
    end

    metp_front #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .frame_start (frame_start),
        .cfg         (map_cfg),
        .job_wr      (job_wr),
        .job_data    (job_in),
        .job_full    (job_full)
    );

    metp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_rd),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    metp_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_empty       (job_empty),
        .job_rd          (job_rd),
        .job_data        (job_out),
        .max_iterations  (max_iter_reg),
        .pop             (pop),
        .empty           (empty),
        .iteration_count (iteration_count),
        .inside_res      (inside_res),
        .level           (level),
        .inside_count    (inside_count)
    );

endmodule
